[hdl/tga_prm_pkg.sv]
package tga_prm_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_end;
    } t_byte_in;

    typedef struct packed {
        logic [7:0]  pix_blue;
        logic [7:0]  pix_green;
        logic [7:0]  pix_red;
        logic [7:0]  pix_alpha;
        logic [15:0] pix_col;
        logic [15:0] pix_row;
        logic        image_done;
        logic [2:0]  status;
    } t_pix_out;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        ST_PIXEL        = 3'd0,
        ST_SHORT_HEADER = 3'd1,
        ST_COLOR_MAPPED = 3'd2,
        ST_ZERO_SIZE    = 3'd3,
        ST_BAD_TYPE     = 3'd4,
        ST_BAD_GREY     = 3'd5,
        ST_BAD_COLOR    = 3'd6,
        ST_INCOMPLETE   = 3'd7
    } t_status;

    // header byte offsets
    localparam logic [4:0] HDR_LEN       = 5'd18;
    localparam logic [4:0] HDR_LAST      = HDR_LEN - 5'd1;
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP      = 5'd1;
    localparam logic [4:0] HDR_TYPE      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_GREY      = 8'd3;
    localparam logic [7:0] DEPTH_GREY     = 8'd8;
    localparam logic [7:0] DEPTH_BGR      = 8'd24;
    localparam logic [7:0] DEPTH_BGRA     = 8'd32;
    localparam logic [7:0] TOP_ORIGIN_MASK = 8'h20;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

    localparam logic [2:0] BPP_GREY = 3'd1;
    localparam logic [2:0] BPP_BGR  = 3'd3;
    localparam logic [2:0] BPP_BGRA = 3'd4;

endpackage

[hdl/tga_uncompressed_to_premult_bgra_top.sv]
// Streaming TGA decoder: takes one file byte per transaction and returns premultiplied
// BGRA pixels with their destination column and row, or a status item when the header
// is bad or the file ends early. A byte is taken in every cycle while o_stall is low; a
// pixel is parsed from its last byte into the pixel register, then goes through the three
// 8x8 premultiply multipliers and the divide-by-255 correction into the output register.
// A byte carrying file_end returns the decoder to its reset state once it is handled,
// so the next byte starts a new file.
module tga_uncompressed_to_premult_bgra_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tga_prm_pkg::t_byte_in i_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tga_prm_pkg::t_pix_out o_pix
);
    import tga_prm_pkg::*;

    // parser state
    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_count, n_hdr_count;
    logic [7:0]  r_id_left, n_id_left;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [2:0]  r_bpp, n_bpp;
    logic        r_top, n_top;
    logic [7:0]  r_cmap, n_cmap;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_depth, n_depth;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [1:0]  r_bip, n_bip;
    logic [7:0]  r_acc0, n_acc0;
    logic [7:0]  r_acc1, n_acc1;
    logic [7:0]  r_acc2, n_acc2;

    // pixel register between parser and premultiply
    logic        r_s1_valid;
    t_pix_out    r_s1, n_s1;
    logic        n_emit;

    t_pix_out    r_out, n_out;
    logic        r_out_valid;

    logic        s2_load;
    logic        s1_load;
    logic        in_take;
    t_status     chk;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        final_pix;
    logic [7:0]  b;

    assign s2_load = !r_out_valid || !i_stall;
    assign s1_load = !r_s1_valid || s2_load;
    assign o_stall = !s1_load;
    assign in_take = i_valid && s1_load;
    assign b       = i_byte.data_byte;
    assign col_inc = {1'b0, r_col} + 17'd1;
    assign row_inc = {1'b0, r_row} + 17'd1;
    assign final_pix = (col_inc == {1'b0, r_width}) && (row_inc == {1'b0, r_height});

    always_comb begin
        priority if (r_cmap != 8'd0) begin
            chk = ST_COLOR_MAPPED;
        end else if (r_width == 16'd0 || r_height == 16'd0) begin
            chk = ST_ZERO_SIZE;
        end else if (r_type != TYPE_TRUECOLOR && r_type != TYPE_GREY) begin
            chk = ST_BAD_TYPE;
        end else if (r_type == TYPE_GREY && r_depth != DEPTH_GREY) begin
            chk = ST_BAD_GREY;
        end else if (r_type == TYPE_TRUECOLOR && r_depth != DEPTH_BGR
                     && r_depth != DEPTH_BGRA) begin
            chk = ST_BAD_COLOR;
        end else begin
            chk = ST_PIXEL;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_count = r_hdr_count;
        n_id_left   = r_id_left;
        n_width     = r_width;
        n_height    = r_height;
        n_bpp       = r_bpp;
        n_top       = r_top;
        n_cmap      = r_cmap;
        n_type      = r_type;
        n_depth     = r_depth;
        n_col       = r_col;
        n_row       = r_row;
        n_bip       = r_bip;
        n_acc0      = r_acc0;
        n_acc1      = r_acc1;
        n_acc2      = r_acc2;
        n_emit      = 1'b0;
        n_s1        = '0;

        unique case (r_phase)
            PH_HEADER: begin
                priority if (r_hdr_count == HDR_ID_LEN)    n_id_left = b;
                else if (r_hdr_count == HDR_CMAP)          n_cmap = b;
                else if (r_hdr_count == HDR_TYPE)          n_type = b;
                else if (r_hdr_count == HDR_WIDTH_LO)      n_width[7:0] = b;
                else if (r_hdr_count == HDR_WIDTH_HI)      n_width[15:8] = b;
                else if (r_hdr_count == HDR_HEIGHT_LO)     n_height[7:0] = b;
                else if (r_hdr_count == HDR_HEIGHT_HI)     n_height[15:8] = b;
                else if (r_hdr_count == HDR_DEPTH)         n_depth = b;
                else if (r_hdr_count == HDR_LAST)          n_top = (b & TOP_ORIGIN_MASK) != 8'd0;
                else                                       n_hdr_count = r_hdr_count;

                if (r_hdr_count < HDR_LAST) begin
                    n_hdr_count = r_hdr_count + 5'd1;
                    if (i_byte.file_end) begin
                        n_emit      = 1'b1;
                        n_s1.status = ST_SHORT_HEADER;
                    end
                end else if (chk != ST_PIXEL) begin
                    n_phase     = PH_ERROR;
                    n_emit      = 1'b1;
                    n_s1.status = chk;
                end else begin
                    if (r_type == TYPE_GREY) begin
                        n_bpp = BPP_GREY;
                    end else if (r_depth == DEPTH_BGR) begin
                        n_bpp = BPP_BGR;
                    end else begin
                        n_bpp = BPP_BGRA;
                    end
                    n_phase = (r_id_left == 8'd0) ? PH_PIXELS : PH_ID;
                    if (i_byte.file_end) begin
                        n_emit      = 1'b1;
                        n_s1.status = ST_INCOMPLETE;
                    end
                end
            end
            PH_ID: begin
                n_id_left = r_id_left - 8'd1;
                if (n_id_left == 8'd0) begin
                    n_phase = PH_PIXELS;
                end
                if (i_byte.file_end) begin
                    n_emit      = 1'b1;
                    n_s1.status = ST_INCOMPLETE;
                end
            end
            PH_PIXELS: begin
                if ({1'b0, r_bip} + 3'd1 < r_bpp) begin
                    unique case (r_bip)
                        2'd0:    n_acc0 = b;
                        2'd1:    n_acc1 = b;
                        default: n_acc2 = b;
                    endcase
                    n_bip = r_bip + 2'd1;
                    if (i_byte.file_end) begin
                        n_emit      = 1'b1;
                        n_s1.status = ST_INCOMPLETE;
                    end
                end else begin
                    n_bip  = 2'd0;
                    n_emit = 1'b1;
                    if (!final_pix && i_byte.file_end) begin
                        n_s1.status = ST_INCOMPLETE;
                    end else begin
                        unique case (r_bpp)
                            BPP_GREY: begin
                                n_s1.pix_blue  = b;
                                n_s1.pix_green = b;
                                n_s1.pix_red   = b;
                                n_s1.pix_alpha = ALPHA_OPAQUE;
                            end
                            BPP_BGR: begin
                                n_s1.pix_blue  = r_acc0;
                                n_s1.pix_green = r_acc1;
                                n_s1.pix_red   = b;
                                n_s1.pix_alpha = ALPHA_OPAQUE;
                            end
                            default: begin
                                n_s1.pix_blue  = r_acc0;
                                n_s1.pix_green = r_acc1;
                                n_s1.pix_red   = r_acc2;
                                n_s1.pix_alpha = b;
                            end
                        endcase
                        n_s1.pix_col    = r_col;
                        n_s1.pix_row    = r_top ? r_row : (r_height - 16'd1 - r_row);
                        n_s1.image_done = final_pix;
                        n_s1.status     = ST_PIXEL;
                        if (final_pix) begin
                            n_phase = PH_DONE;
                        end else if (col_inc >= {1'b0, r_width}) begin
                            n_col = 16'd0;
                            n_row = row_inc[15:0];
                        end else begin
                            n_col = col_inc[15:0];
                        end
                    end
                end
            end
            default: begin
                // done or error: drop bytes until the end of the file
            end
        endcase

        if (i_byte.file_end) begin
            n_phase     = PH_HEADER;
            n_hdr_count = 5'd0;
            n_id_left   = 8'd0;
            n_width     = 16'd0;
            n_height    = 16'd0;
            n_bpp       = 3'd0;
            n_top       = 1'b0;
            n_cmap      = 8'd0;
            n_type      = 8'd0;
            n_depth     = 8'd0;
            n_col       = 16'd0;
            n_row       = 16'd0;
            n_bip       = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_count <= 5'd0;
            r_id_left   <= 8'd0;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_bpp       <= 3'd0;
            r_top       <= 1'b0;
            r_cmap      <= 8'd0;
            r_type      <= 8'd0;
            r_depth     <= 8'd0;
            r_col       <= 16'd0;
            r_row       <= 16'd0;
            r_bip       <= 2'd0;
        end else if (in_take) begin
            r_phase     <= n_phase;
            r_hdr_count <= n_hdr_count;
            r_id_left   <= n_id_left;
            r_width     <= n_width;
            r_height    <= n_height;
            r_bpp       <= n_bpp;
            r_top       <= n_top;
            r_cmap      <= n_cmap;
            r_type      <= n_type;
            r_depth     <= n_depth;
            r_col       <= n_col;
            r_row       <= n_row;
            r_bip       <= n_bip;
        end
    end

    // pixel bytes are always written before they are read, so no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_acc0 <= n_acc0;
            r_acc1 <= n_acc1;
            r_acc2 <= n_acc2;
        end
        if (s1_load) begin
            r_s1 <= n_s1;
        end
        if (s2_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= in_take && n_emit;
            end
            if (s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // c*a/255 for c*a <= 255*255: (x + 1 + (x >> 8)) >> 8
    function automatic logic [7:0] premult(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] x;
        logic [16:0] s;
        x = c * a;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    always_comb begin
        n_out           = r_s1;
        n_out.pix_blue  = premult(r_s1.pix_blue, r_s1.pix_alpha);
        n_out.pix_green = premult(r_s1.pix_green, r_s1.pix_alpha);
        n_out.pix_red   = premult(r_s1.pix_red, r_s1.pix_alpha);
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule
